### rtl/gco_pkg.sv
`default_nettype none

package gco_pkg;

   localparam int GENE_WIDTH   = 32;
   localparam int MAX_GENES    = 1024;
   localparam int POS_WIDTH    = $clog2(MAX_GENES);
   localparam int CUT_WIDTH    = 10;
   localparam int WEIGHT_WIDTH = 16;
   localparam int MODE_WIDTH   = 3;

   localparam int REQ_DATA_BITS  = 2 * GENE_WIDTH + 2 * CUT_WIDTH + 3 + WEIGHT_WIDTH;
   localparam int REQ_DATA_WIDTH = ((REQ_DATA_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = ((GENE_WIDTH + 7) / 8) * 8;

   localparam logic [POS_WIDTH-1:0] POS_LAST = POS_WIDTH'(MAX_GENES - 1);

   localparam logic [MODE_WIDTH-1:0] MODE_ONE_POINT = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_TWO_POINT = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_UNIFORM   = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_FLAT      = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_DISCRETE  = 3'd4;

   typedef struct packed {
      logic signed [GENE_WIDTH-1:0] first_gene;
      logic signed [GENE_WIDTH-1:0] second_gene;
      logic [CUT_WIDTH-1:0]         cut_a;
      logic [CUT_WIDTH-1:0]         cut_b;
      logic                         pick_second;
      logic                         bit_a;
      logic                         bit_b;
      logic [WEIGHT_WIDTH-1:0]      weight;
      logic                         last;
      logic [POS_WIDTH-1:0]         position;
   } gco_item_type;

endpackage

`default_nettype wire

### rtl/genetic_crossover_unit_core.sv
`default_nettype none

// Streaming crossover of two parent genomes, one child gene per parent pair.
// req_ carries both parent genes plus the random draws for that gene; tlast
// marks the final gene of a genome and restarts the position counter.
// rsp_ returns the child gene with tlast copied from the request.
// csr_wr_en/csr_wr_data set the crossover mode; write only while idle.
// The request is taken into the input register, then the operator logic,
// with one 17x33 multiply, feeds the result register that drives rsp_.
// Throughput: one gene per cycle while rsp_tready is high, set by the
// two-stage register pipeline; each stage moves when the one after it is
// empty or draining.
// A stalled rsp_tready holds the result; one more request is taken into the
// input register, then req_tready drops until the response is transferred.
// Reset (synchronous) empties both stages, clears the position counter and
// sets the mode to one-point.
module genetic_crossover_unit_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // [31:0] first_parent_gene, [63:32] second_parent_gene, [73:64] cut_draw_a,
   // [83:74] cut_draw_b, [84] pick_second_child, [85] gene_bit_a,
   // [86] gene_bit_b, [102:87] blend_weight, [103] zero pad
   input  wire logic [gco_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   input  wire logic                                 req_tlast,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [31:0] child_gene
   output logic [gco_pkg::RSP_DATA_WIDTH-1:0]        rsp_tdata,
   output logic                                      rsp_tlast,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic                                 csr_wr_en,
   input  wire logic [gco_pkg::MODE_WIDTH-1:0]       csr_wr_data
);
   import gco_pkg::*;

   localparam int OFS_B    = GENE_WIDTH;
   localparam int OFS_CA   = 2 * GENE_WIDTH;
   localparam int OFS_CB   = OFS_CA + CUT_WIDTH;
   localparam int OFS_PICK = OFS_CB + CUT_WIDTH;
   localparam int OFS_W    = OFS_PICK + 3;

   logic [MODE_WIDTH-1:0]        mode_ff;
   logic [POS_WIDTH-1:0]         pos_ff, pos_in;
   gco_item_type                 item_ff, item_in;
   logic                         item_valid_ff;
   logic signed [GENE_WIDTH-1:0] child_gene;
   logic [GENE_WIDTH-1:0]        child_ff;
   logic                         child_last_ff;
   logic                         rsp_valid_ff;
   logic                         stage_move;
   logic                         req_xfer;

   always_comb begin
      stage_move = !rsp_valid_ff || rsp_tready;
      req_tready = !item_valid_ff || stage_move;
      req_xfer   = req_tvalid && req_tready;

      item_in.first_gene  = $signed(req_tdata[GENE_WIDTH-1:0]);
      item_in.second_gene = $signed(req_tdata[OFS_B +: GENE_WIDTH]);
      item_in.cut_a       = req_tdata[OFS_CA +: CUT_WIDTH];
      item_in.cut_b       = req_tdata[OFS_CB +: CUT_WIDTH];
      item_in.pick_second = req_tdata[OFS_PICK];
      item_in.bit_a       = req_tdata[OFS_PICK + 1];
      item_in.bit_b       = req_tdata[OFS_PICK + 2];
      item_in.weight      = req_tdata[OFS_W +: WEIGHT_WIDTH];
      item_in.last        = req_tlast;
      item_in.position    = pos_ff;

      if (req_tlast || pos_ff == POS_LAST) begin
         pos_in = '0;
      end else begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ONE_POINT;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_xfer) begin
            pos_ff <= pos_in;
         end
         if (req_tready) begin
            item_valid_ff <= req_tvalid;
         end
         if (stage_move) begin
            rsp_valid_ff <= item_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff <= item_in;
      end
      if (stage_move && item_valid_ff) begin
         child_ff      <= child_gene;
         child_last_ff <= item_ff.last;
      end
   end

   gco_operator u_operator (
      .item       (item_ff),
      .mode       (mode_ff),
      .child_gene (child_gene)
   );

   assign rsp_tdata  = RSP_DATA_WIDTH'(child_ff);
   assign rsp_tlast  = child_last_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/gco_operator.sv
`default_nettype none

module gco_operator (
   input  wire gco_pkg::gco_item_type              item,
   input  wire logic [gco_pkg::MODE_WIDTH-1:0]     mode,
   output logic signed [gco_pkg::GENE_WIDTH-1:0]   child_gene
);
   import gco_pkg::*;

   logic                         one_swap;
   logic                         two_swap;
   logic [CUT_WIDTH-1:0]         cut_lo;
   logic [CUT_WIDTH-1:0]         cut_hi;
   logic signed [GENE_WIDTH:0]   diff;
   logic signed [GENE_WIDTH+WEIGHT_WIDTH+1:0] prod;
   logic signed [GENE_WIDTH:0]   blend_sum;
   logic signed [GENE_WIDTH-1:0] c1;
   logic signed [GENE_WIDTH-1:0] c2;

   always_comb begin
      one_swap = item.position >= item.cut_a;
      cut_lo   = (item.cut_a < item.cut_b) ? item.cut_a : item.cut_b;
      cut_hi   = (item.cut_a < item.cut_b) ? item.cut_b : item.cut_a;
      two_swap = (item.position >= cut_lo) && (item.position < cut_hi);

      // arithmetic shift of the signed product gives the floor
      diff      = {item.first_gene[GENE_WIDTH-1], item.first_gene}
                - {item.second_gene[GENE_WIDTH-1], item.second_gene};
      prod      = $signed({1'b0, item.weight}) * diff;
      blend_sum = {item.second_gene[GENE_WIDTH-1], item.second_gene}
                + prod[GENE_WIDTH+WEIGHT_WIDTH:WEIGHT_WIDTH];

      c1 = item.first_gene;
      c2 = item.second_gene;
      child_gene = item.first_gene;
      unique case (mode)
         MODE_ONE_POINT: begin
            c1 = one_swap ? item.second_gene : item.first_gene;
            c2 = one_swap ? item.first_gene : item.second_gene;
            child_gene = item.pick_second ? c2 : c1;
         end
         MODE_TWO_POINT: begin
            c1 = two_swap ? item.second_gene : item.first_gene;
            c2 = two_swap ? item.first_gene : item.second_gene;
            child_gene = item.pick_second ? c2 : c1;
         end
         MODE_UNIFORM: begin
            c1 = item.bit_a ? item.second_gene : item.first_gene;
            c2 = item.bit_b ? item.first_gene : item.second_gene;
            child_gene = item.pick_second ? c2 : c1;
         end
         MODE_FLAT: begin
            child_gene = blend_sum[GENE_WIDTH-1:0];
         end
         MODE_DISCRETE: begin
            child_gene = item.bit_a ? item.first_gene : item.second_gene;
         end
         default: begin
            child_gene = item.first_gene;
         end
      endcase
   end

endmodule

`default_nettype wire
